[src/skct_pkg.sv]
package skct_pkg;

  // table size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int PLAYER_W = 8;
  localparam int CLASS_W  = 15;
  localparam int NUMBER_W = 15;
  localparam int KEY_W    = PLAYER_W + CLASS_W + NUMBER_W;
  localparam int CNT_W    = 31;
  localparam int IDX_W    = 6;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INC   = 2'd0,
    OP_SET   = 2'd1,
    OP_QUERY = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // one stored entry, key above count
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = KEY_W + CNT_W;

  // table memory access from the sequencer
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    entry_t             wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              found;
    logic              status;
    logic [KEY_W-1:0]  key;
    logic [FILL_W-1:0] fill;
  } res_t;

endpackage

[src/skct_ram.sv]
module skct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/skct_seq.sv]
module skct_seq import skct_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [PLAYER_W-1:0] player,
  input  logic [CLASS_W-1:0]  unit_class,
  input  logic [NUMBER_W-1:0] unit_number,
  input  logic [CNT_W-1:0]    loss_value,
  input  logic [IDX_W-1:0]    entry_index,
  output logic                res_valid,
  input  logic                res_take,
  output res_t                res,
  output mem_req_t            mem_req,
  input  entry_t              rdata
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_DECIDE = 8'b0000_0100,
    ST_SHIFT  = 8'b0000_1000,
    ST_INSERT = 8'b0001_0000,
    ST_RD     = 8'b0010_0000,
    ST_RDWAIT = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [FILL_W-1:0]  used;
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [CNT_W-1:0]   val_r;
  logic [IDX_W-1:0]   idx_r;
  logic [FILL_W-1:0]  pos;
  logic               pend;
  logic               hit;
  logic [CNT_W-1:0]   hit_cnt;
  logic [FILL_W-1:0]  rem;
  logic [ADDR_W-1:0]  wptr;
  logic [ADDR_W-1:0]  rptr;

  logic [CNT_W-1:0]   upd_cnt;
  logic [CNT_W-1:0]   ins_cnt;
  logic [FILL_W-1:0]  pos_inc;
  logic               scan_end;
  logic               scan_stop;
  logic               idx_ok;

  assign in_stall  = (state != ST_IDLE);
  assign res_valid = (state == ST_FINISH);

  // new count for a present key (saturating increment or overwrite) and for an inserted key
  always_comb begin
    if (op_r == OP_INC) begin
      upd_cnt = (hit_cnt == COUNT_MAX) ? COUNT_MAX : hit_cnt + CNT_W'(1);
      ins_cnt = CNT_W'(1);
    end else begin
      upd_cnt = val_r;
      ins_cnt = val_r;
    end
  end

  assign pos_inc   = pos + FILL_W'(1);
  assign scan_end  = (pos >= used);
  assign scan_stop = pend && (rdata.key >= key_r);
  assign idx_ok    = (FILL_W'(idx_r) < used);

  // memory port: one read and at most one write a cycle
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = pos[ADDR_W-1:0];
    case (state)
      ST_SCAN: begin
        if (pend) begin
          mem_req.raddr = pos_inc[ADDR_W-1:0];
        end
      end
      ST_DECIDE: begin
        if (hit && (op_r != OP_QUERY)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos[ADDR_W-1:0];
          mem_req.wdata = '{key: key_r, cnt: upd_cnt};
        end
      end
      ST_SHIFT: begin
        mem_req.raddr = rptr;
        if (pend) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wptr;
          mem_req.wdata = rdata;
        end
      end
      ST_INSERT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos[ADDR_W-1:0];
        mem_req.wdata = '{key: key_r, cnt: ins_cnt};
      end
      ST_RD: begin
        mem_req.raddr = ADDR_W'(idx_r);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_r  <= op_t'(op);
            key_r <= {player, unit_class, unit_number};
            val_r <= loss_value;
            idx_r <= entry_index;
            pos   <= '0;
            pend  <= 1'b0;
            state <= (op_t'(op) == OP_READ) ? ST_RD : ST_SCAN;
          end
        end
        // linear search for the first key not below the item key
        ST_SCAN: begin
          if (scan_end) begin
            hit   <= 1'b0;
            pend  <= 1'b0;
            state <= ST_DECIDE;
          end else if (!pend) begin
            pend <= 1'b1;
          end else if (scan_stop) begin
            hit     <= (rdata.key == key_r);
            hit_cnt <= rdata.cnt;
            pend    <= 1'b0;
            state   <= ST_DECIDE;
          end else begin
            pos <= pos_inc;
          end
        end
        ST_DECIDE: begin
          if (op_r == OP_QUERY) begin
            res   <= '{count: hit ? hit_cnt : CNT_W'(0), found: hit, status: 1'b0,
                       key: '0, fill: used};
            state <= ST_FINISH;
          end else if (hit) begin
            res   <= '{count: upd_cnt, found: 1'b1, status: 1'b0, key: '0, fill: used};
            state <= ST_FINISH;
          end else if (used == FILL_W'(CAPACITY)) begin
            res   <= '{count: '0, found: 1'b0, status: 1'b1, key: '0, fill: used};
            state <= ST_FINISH;
          end else begin
            rem   <= used - pos;
            wptr  <= used[ADDR_W-1:0];
            rptr  <= ADDR_W'(used - FILL_W'(1));
            pend  <= 1'b0;
            state <= ST_SHIFT;
          end
        end
        // move later entries up by one place, top first
        ST_SHIFT: begin
          if (pend) begin
            wptr <= wptr - ADDR_W'(1);
          end
          if (rem != '0) begin
            rptr <= rptr - ADDR_W'(1);
            rem  <= rem - FILL_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_INSERT;
            end
          end
        end
        ST_INSERT: begin
          used  <= used + FILL_W'(1);
          res   <= '{count: ins_cnt, found: 1'b0, status: 1'b0, key: '0,
                     fill: used + FILL_W'(1)};
          state <= ST_FINISH;
        end
        ST_RD: begin
          res   <= '{count: '0, found: 1'b0, status: 1'b0, key: '0, fill: used};
          state <= idx_ok ? ST_RDWAIT : ST_FINISH;
        end
        ST_RDWAIT: begin
          res   <= '{count: rdata.cnt, found: 1'b1, status: 1'b0, key: rdata.key,
                     fill: used};
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/sorted_keyed_counter_table_core.sv]
// Sorted table of up to 64 saturating counters filed under the key
// {player, unit_class, unit_number}, kept in ascending key order.
// Input channel: in_valid / in_stall with op, key fields, loss_value and
// entry_index; an item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with count, found, status, the
// entry key fields and fill_level; one result item per input item.
// One item at a time: in_stall stays high from acceptance until the result
// has been moved into the output register, so the next item can be taken
// in the cycle after the previous result is loaded.
// Steps, from the accepting edge to the edge loading the output register:
// a read passes ST_RD and ST_RDWAIT (ST_RD only at or beyond the fill
// level); a query, an increment or set of a present key, or a refused
// insert passes ST_SCAN, with its one-entry-a-cycle search through the
// table memory's read port, and ST_DECIDE; an insert goes on through
// ST_SHIFT, which moves later entries up sharing the same memory ports,
// and ST_INSERT. Every result then waits in ST_FINISH until taken.
// A result waiting in the output register does not block the next item;
// while out_stall is high a second finished result waits in the sequencer.
// Reset empties the table at once (internal fill count to zero); no clearing pass.
module sorted_keyed_counter_table_core import skct_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [PLAYER_W-1:0] player,
  input  logic [CLASS_W-1:0]  unit_class,
  input  logic [NUMBER_W-1:0] unit_number,
  input  logic [CNT_W-1:0]    loss_value,
  input  logic [IDX_W-1:0]    entry_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CNT_W-1:0]    count,
  output logic                found,
  output logic                status,
  output logic [PLAYER_W-1:0] entry_player,
  output logic [CLASS_W-1:0]  entry_class,
  output logic [NUMBER_W-1:0] entry_number,
  output logic [FILL_W-1:0]   fill_level
);

  mem_req_t mem_req;
  entry_t   rdata;
  res_t     res;
  logic     res_valid;
  logic     res_take;
  logic [ENTRY_W-1:0] rdata_raw;

  // key and count table
  skct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  // search, update and shift sequencer
  skct_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .player      (player),
    .unit_class  (unit_class),
    .unit_number (unit_number),
    .loss_value  (loss_value),
    .entry_index (entry_index),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_req     (mem_req),
    .rdata       (rdata)
  );

  // output register, loaded when empty or being taken
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      count        <= res.count;
      found        <= res.found;
      status       <= res.status;
      entry_player <= res.key[KEY_W-1 -: PLAYER_W];
      entry_class  <= res.key[NUMBER_W +: CLASS_W];
      entry_number <= res.key[NUMBER_W-1:0];
      fill_level   <= res.fill;
    end
  end

endmodule
